// File: sv/vim_pkg.sv
// Shared widths, types and arithmetic helpers for the 3D vector magnitude block.
// Used by vim_front, vim_queue, vim_back and the top level; depends on nothing.
package vim_pkg;

  localparam int COORD_BITS = 15;                  // significant bits of each coordinate
  localparam int FIELD_BITS = 15;                  // width of a coordinate port
  localparam int MAG_BITS   = 15;                  // width of the magnitude port
  localparam int ABS_BITS   = COORD_BITS;          // |coord| reaches 2^(COORD_BITS-1)
  localparam int SQ_BITS    = 2 * COORD_BITS - 1;  // largest square is 2^(2*COORD_BITS-2)
  localparam int SUM_BITS   = 2 * COORD_BITS;      // three squares stay below 2^(2*COORD_BITS)
  localparam int ROOT_BITS  = 16;                  // root is found over bits 15 down to 0
  localparam int RAD_BITS   = 2 * ROOT_BITS;       // radicand consumed two bits per step
  localparam int REM_BITS   = ROOT_BITS + 2;       // partial remainder stays below 2^(ROOT_BITS+1)
  localparam int TRIAL_BITS = REM_BITS + 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  // One sum handed from the front to the queue.
  typedef struct packed {
    logic                valid;
    logic [SUM_BITS-1:0] sum;
  } vim_push_t;

  // Result of one digit step of the square root.
  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } vim_step_t;

  // Absolute value of the low COORD_BITS bits of a field, read as two's complement.
  function automatic logic [ABS_BITS-1:0] coord_abs(input logic [FIELD_BITS-1:0] raw);
    logic [COORD_BITS-1:0] v;
    v = raw[COORD_BITS-1:0];
    if (v[COORD_BITS-1]) begin
      return ABS_BITS'(-v);
    end
    return ABS_BITS'(v);
  endfunction

  // One restoring square-root step: bring in the next two radicand bits and try a one.
  function automatic vim_step_t sqrt_step(input logic [REM_BITS-1:0]  rem,
                                          input logic [ROOT_BITS-1:0] root,
                                          input logic [1:0]           pair);
    logic [TRIAL_BITS-1:0] trial;
    logic [TRIAL_BITS-1:0] cand;
    logic [TRIAL_BITS-1:0] diff;
    vim_step_t             res;
    trial = {rem, pair};
    cand  = {{(TRIAL_BITS - ROOT_BITS - 2){1'b0}}, root, 2'b01};
    diff  = trial - cand;
    if (trial >= cand) begin
      res.rem  = diff[REM_BITS-1:0];
      res.root = {root[ROOT_BITS-2:0], 1'b1};
    end else begin
      res.rem  = trial[REM_BITS-1:0];
      res.root = {root[ROOT_BITS-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// File: sv/vim_front.sv
// Front part of the magnitude block: accepts vectors and squares the coordinates.
// Depends on vim_pkg; feeds vim_queue with the sum of squares.
module vim_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vim_pkg::FIELD_BITS-1:0] vec_x_i,
  input  logic [vim_pkg::FIELD_BITS-1:0] vec_y_i,
  input  logic [vim_pkg::FIELD_BITS-1:0] vec_z_i,
  input  logic                          full_i,
  output vim_pkg::vim_push_t            push_o
);
  import vim_pkg::*;

  logic                  valid_q;
  logic                  valid_d;
  logic [SQ_BITS-1:0]    sq_x_q, sq_y_q, sq_z_q;
  logic [ABS_BITS-1:0]   ax, ay, az;
  logic [2*ABS_BITS-1:0] px, py, pz;
  logic                  load;

  // The square register moves on whenever it is empty or the queue takes its sum.
  assign in_stall_o = valid_q && full_i;
  assign load       = in_valid_i && !in_stall_o;

  assign ax = coord_abs(vec_x_i);
  assign ay = coord_abs(vec_y_i);
  assign az = coord_abs(vec_z_i);
  assign px = ax * ax;
  assign py = ay * ay;
  assign pz = az * az;

  always_comb begin
    valid_d = valid_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sq_x_q <= px[SQ_BITS-1:0];
      sq_y_q <= py[SQ_BITS-1:0];
      sq_z_q <= pz[SQ_BITS-1:0];
    end
  end

  assign push_o.valid = valid_q;
  assign push_o.sum   = SUM_BITS'(sq_x_q) + SUM_BITS'(sq_y_q) + SUM_BITS'(sq_z_q);

endmodule

// File: sv/vim_queue.sv
// Short FIFO of sums of squares between the front and the root pipeline.
// Depends on vim_pkg for its depth and entry width.
module vim_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vim_pkg::vim_push_t            push_i,
  output logic                          full_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [vim_pkg::SUM_BITS-1:0]  sum_o
);
  import vim_pkg::*;

  logic [SUM_BITS-1:0]  mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == QCNT_BITS'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign sum_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.sum;
    end
  end

endmodule

// File: sv/vim_back.sv
// Back part of the magnitude block: a pipelined square root, one root bit per stage.
// Depends on vim_pkg for widths and the digit step; pulls sums from vim_queue.
module vim_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  logic [vim_pkg::SUM_BITS-1:0]  sum_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vim_pkg::MAG_BITS-1:0]  magnitude_o
);
  import vim_pkg::*;

  logic                 valid_q [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_q   [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q  [ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_q   [ROOT_BITS];
  vim_step_t            step    [ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_in;
  logic                 adv;

  // The whole pipeline moves together unless a finished result is held back.
  assign adv    = !(valid_q[ROOT_BITS-1] && out_stall_i);
  assign pop_o  = adv && !empty_i;
  assign rad_in = RAD_BITS'(sum_i);

  assign step[0] = sqrt_step('0, '0, rad_in[RAD_BITS-1 -: 2]);

  for (genvar s = 1; s < ROOT_BITS; s++) begin : g_step
    assign step[s] = sqrt_step(rem_q[s-1], root_q[s-1], rad_q[s-1][RAD_BITS-1 -: 2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < ROOT_BITS; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (adv) begin
      valid_q[0] <= !empty_i;
      for (int s = 1; s < ROOT_BITS; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= step[0].rem;
      root_q[0] <= step[0].root;
      rad_q[0]  <= {rad_in[RAD_BITS-3:0], 2'b00};
      for (int s = 1; s < ROOT_BITS; s++) begin
        rem_q[s]  <= step[s].rem;
        root_q[s] <= step[s].root;
        rad_q[s]  <= {rad_q[s-1][RAD_BITS-3:0], 2'b00};
      end
    end
  end

  assign out_valid_o = valid_q[ROOT_BITS-1];
  assign magnitude_o = root_q[ROOT_BITS-1][MAG_BITS-1:0];

endmodule

// File: sv/vector3_integer_magnitude.sv
// Top level of the 3D vector magnitude block: floor(sqrt(x*x + y*y + z*z)).
// Depends on vim_pkg, vim_front, vim_queue and vim_back.
//
// Usage: a vector is one beat on the input channel (in_valid_i, in_stall_o and the
// three signed coordinate ports); it is taken at a rising edge with in_valid_i high
// and in_stall_o low. Each coordinate is read from its low COORD_BITS bits as a
// two's complement number. Every input beat yields exactly one output beat
// (out_valid_o, out_stall_i, magnitude_o), in order.
// Path of a beat: with no stall and an empty queue, the squares are registered at the
// accepting edge, their sum is then written into the four-entry queue, and the root is
// settled in the sixteen pipeline stages, one root bit per stage.
// Throughput: one beat per cycle when no stall holds the flow; the root pipeline takes
// a new sum every cycle while not held, the front squares one vector every cycle.
// When the receiver stalls, the root pipeline freezes as a whole while its last stage
// holds a result. The front keeps taking beats until the queue fills; then
// in_stall_o rises and stays high until the pipeline drains an entry.
// Reset empties the queue and clears all valid flags; no result is in flight after it.
module vector3_integer_magnitude (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vim_pkg::FIELD_BITS-1:0] vec_x_i,
  input  logic [vim_pkg::FIELD_BITS-1:0] vec_y_i,
  input  logic [vim_pkg::FIELD_BITS-1:0] vec_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vim_pkg::MAG_BITS-1:0]  magnitude_o
);
  import vim_pkg::*;

  vim_push_t           push;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  logic [SUM_BITS-1:0] q_sum;

  // Front: coordinate magnitudes and squares, then the sum offered to the queue.
  vim_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .full_i     (q_full),
    .push_o     (push)
  );

  // The queue lets the front keep accepting while the output side is stalled.
  vim_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .sum_o   (q_sum)
  );

  // Back: sixteen-stage digit-by-digit square root; its last stage is the output register.
  vim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .sum_i       (q_sum),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .magnitude_o (magnitude_o)
  );

endmodule
